### rtl/mcss_pkg.sv
// Shared types for the Markov chain sampler and scorer.
package mcss_pkg;

  typedef enum logic [1:0] {
    FUNC_WR_TRANS = 2'd0,
    FUNC_WR_INIT  = 2'd1,
    FUNC_SAMPLE   = 2'd2,
    FUNC_SCORE    = 2'd3
  } func_e;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_SCORE  = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_SCORE_MUL,
    ST_SCORE_FIN
  } state_e;

  typedef struct packed {
    func_e       func;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [15:0] prob_value;
    logic [15:0] uniform;
    logic [3:0]  symbol;
    logic        first;
  } req_t;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  sampled_state;
    logic [15:0] probability;
  } res_t;

  typedef struct packed {
    logic capture;
    logic clear;
    logic write;
    logic prime;
    logic score_rd;
    logic walk;
    logic score_mul;
    logic score_fin;
    logic emit;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  first;
    logic  clear_last;
    logic  walk_done;
  } sts_t;

endpackage

### rtl/mcss_ctrl.sv
// Sequencing state machine for the Markov chain sampler and scorer.
module mcss_ctrl import mcss_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        case (sts_i.func)
          FUNC_SAMPLE: state_d = ST_WALK;
          FUNC_SCORE:  state_d = ST_SCORE_MUL;
          default:     state_d = ST_IDLE;
        endcase
      end
      ST_WALK: begin
        if (sts_i.walk_done) state_d = ST_IDLE;
      end
      ST_SCORE_MUL: begin
        state_d = sts_i.first ? ST_IDLE : ST_SCORE_FIN;
      end
      ST_SCORE_FIN: state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      ST_CLEAR: cmd_o.clear = 1'b1;
      ST_IDLE: begin
        busy          = 1'b0;
        cmd_o.capture = start;
      end
      ST_EXEC: begin
        cmd_o.write    = (sts_i.func == FUNC_WR_TRANS) || (sts_i.func == FUNC_WR_INIT);
        cmd_o.prime    = (sts_i.func == FUNC_SAMPLE);
        cmd_o.score_rd = (sts_i.func == FUNC_SCORE);
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
        cmd_o.emit = sts_i.walk_done;
      end
      ST_SCORE_MUL: begin
        cmd_o.score_mul = 1'b1;
        cmd_o.emit      = sts_i.first;
      end
      ST_SCORE_FIN: begin
        cmd_o.score_fin = 1'b1;
        cmd_o.emit      = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

### rtl/mcss_dp.sv
// Datapath: probability memory, cumulative walk, score multiplier, result register.
module mcss_dp import mcss_pkg::*; #(
  parameter int unsigned NUM_STATES = 16,
  parameter int unsigned PROB_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output res_t res_o,
  output logic done_o
);

  localparam int unsigned SW    = $clog2(NUM_STATES);
  localparam int unsigned RW    = $clog2(NUM_STATES + 1);
  localparam int unsigned AW    = RW + SW;
  localparam int unsigned PW    = PROB_BITS;
  localparam int unsigned DEPTH = 2 ** AW;
  localparam int unsigned SUMW  = PW + SW;

  // Rows 0..NUM_STATES-1 hold transitions, row NUM_STATES the initial vector.
  logic [PW-1:0] mem_q [DEPTH];

  req_t            req_q;
  logic [PW-1:0]   rdata_q;
  logic [SUMW-1:0] sum_q;
  logic [SW-1:0]   walk_q;
  logic [2*PW-1:0] prod_q;
  logic            ok_q;
  res_t            res_q;
  logic            done_q;
  logic [SW-1:0]   cur_state_q;
  logic [3:0]      last_sym_q;
  logic [PW-1:0]   running_q;
  logic [AW-1:0]   clr_q;

  logic [PW+15:0]  pv_wide, u_wide, run_wide;
  logic [PW-1:0]   pv, u_pw, ent;
  logic [RW+3:0]   row_wide, last_wide;
  logic [SW+3:0]   col_wide, sym_wide, walk_wide;
  logic [RW+SW-1:0] cur_wide;
  logic [RW-1:0]   row_rw, last_rw, sample_row, init_row;
  logic [SW-1:0]   col_sw, sym_sw;
  logic            row_ok, col_ok, sym_ok, last_ok, score_ok;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic            wr_en;
  logic [PW-1:0]   wr_data;
  logic [SUMW-1:0] sum_d, u_ext, ent_ext;
  logic            walk_done;
  logic [PW-1:0]   running_d;
  logic [PW-1:0]   result_prob;

  assign pv_wide   = {{PW{1'b0}}, req_q.prob_value};
  assign u_wide    = {{PW{1'b0}}, req_q.uniform};
  assign pv        = pv_wide[PW-1:0];
  assign u_pw      = u_wide[PW-1:0];
  assign row_wide  = {{RW{1'b0}}, req_q.row};
  assign last_wide = {{RW{1'b0}}, last_sym_q};
  assign col_wide  = {{SW{1'b0}}, req_q.col};
  assign sym_wide  = {{SW{1'b0}}, req_q.symbol};
  assign cur_wide  = {{RW{1'b0}}, cur_state_q};
  assign row_rw    = row_wide[RW-1:0];
  assign last_rw   = last_wide[RW-1:0];
  assign col_sw    = col_wide[SW-1:0];
  assign sym_sw    = sym_wide[SW-1:0];
  assign init_row  = RW'(NUM_STATES);
  assign sample_row = req_q.first ? init_row : cur_wide[RW-1:0];

  assign row_ok   = 32'(req_q.row) < NUM_STATES;
  assign col_ok   = 32'(req_q.col) < NUM_STATES;
  assign sym_ok   = 32'(req_q.symbol) < NUM_STATES;
  assign last_ok  = 32'(last_sym_q) < NUM_STATES;
  assign score_ok = sym_ok && (req_q.first || last_ok);

  always_comb begin
    if (cmd_i.walk) begin
      rd_addr = {sample_row, walk_q + SW'(1)};
    end else if (cmd_i.prime) begin
      rd_addr = {sample_row, SW'(0)};
    end else begin
      rd_addr = {(req_q.first ? init_row : last_rw), sym_sw};
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_q;
    wr_data = '0;
    if (cmd_i.clear) begin
      wr_en = 1'b1;
    end else if (cmd_i.write) begin
      wr_data = pv;
      if (req_q.func == FUNC_WR_TRANS) begin
        wr_en   = row_ok && col_ok;
        wr_addr = {row_rw, col_sw};
      end else begin
        wr_en   = col_ok;
        wr_addr = {init_row, col_sw};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    rdata_q <= mem_q[rd_addr];
  end

  assign ent_ext   = {{SW{1'b0}}, rdata_q};
  assign u_ext     = {{SW{1'b0}}, u_pw};
  assign sum_d     = sum_q + ent_ext;
  assign walk_done = (u_ext < sum_d) || (walk_q == SW'(NUM_STATES - 1));
  assign ent       = ok_q ? rdata_q : '0;
  assign running_d = cmd_i.score_mul ? ent : prod_q[2*PW-1:PW];
  assign run_wide  = {16'b0, running_d};
  assign result_prob = run_wide[15:0];
  assign walk_wide = {4'b0, walk_q};

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) req_q <= req_i;
    if (cmd_i.score_rd) ok_q <= score_ok;
    if (cmd_i.prime) begin
      sum_q  <= '0;
      walk_q <= '0;
    end else if (cmd_i.walk && !walk_done) begin
      sum_q  <= sum_d;
      walk_q <= walk_q + SW'(1);
    end
    if (cmd_i.score_mul && !req_q.first) prod_q <= running_q * ent;
    if (cmd_i.emit) begin
      if (cmd_i.walk) begin
        res_q.kind          <= KIND_SAMPLE;
        res_q.sampled_state <= walk_wide[3:0];
        res_q.probability   <= '0;
      end else begin
        res_q.kind          <= KIND_SCORE;
        res_q.sampled_state <= '0;
        res_q.probability   <= result_prob;
      end
    end
  end

  // Chain state and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_state_q <= '0;
      last_sym_q  <= '0;
      running_q   <= '0;
      clr_q       <= '0;
      done_q      <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
      if (cmd_i.clear) clr_q <= clr_q + AW'(1);
      if (cmd_i.walk && walk_done) cur_state_q <= walk_q;
      if (cmd_i.emit && !cmd_i.walk) begin
        running_q  <= running_d;
        last_sym_q <= req_q.symbol;
      end
    end
  end

  assign sts_o.func       = req_q.func;
  assign sts_o.first      = req_q.first;
  assign sts_o.clear_last = &clr_q;
  assign sts_o.walk_done  = walk_done;
  assign res_o            = res_q;
  assign done_o           = done_q;

endmodule

### rtl/markov_chain_sampler_scorer_top.sv
// Top level of the Markov chain sampler and scorer.
//
//  channel   ports                 handshake
//  request   start, busy, req_i    taken at an edge with start high and busy low
//  result    done_o, res_o         shown for one cycle while done_o is high
//
//  A table write is made in the EXEC state, with busy high.
//  A sample walks one probability entry per cycle, in EXEC and then WALK,
//  up to the picked state; a score runs EXEC, SCORE_MUL, SCORE_FIN if not first.
//  The result appears in the cycle in which busy falls; a new request may
//  be taken in that same cycle. The receiver cannot stall the block.
//  After reset the memory is cleared one entry a cycle, with busy high, all
//  2**(clog2(NUM_STATES+1) + clog2(NUM_STATES)) entries (512 at 16 states).
module markov_chain_sampler_scorer_top import mcss_pkg::*; #(
  parameter int unsigned NUM_STATES = 16,
  parameter int unsigned PROB_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic done_o,
  output res_t res_o
);

  cmd_t cmd;
  sts_t sts;

  mcss_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  mcss_dp #(
    .NUM_STATES (NUM_STATES),
    .PROB_BITS  (PROB_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .res_o  (res_o),
    .done_o (done_o)
  );

`ifndef SYNTHESIS
  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held longer than one cycle");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result shown while block still busy");

  a_accept_no_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !done_o) else $error("result right after request accept");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("block not busy after accepting request");
`endif

endmodule

### dv/markov_chain_sampler_scorer_top_tb.sv
// Self-checking testbench for the Markov chain sampler and scorer.
module markov_chain_sampler_scorer_top_tb import mcss_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSTATES    = 16;
  localparam int RAND_ITEMS = 1700;
  localparam int WATCHDOG   = 4000;
  localparam int QUIET_FROM = 700;
  localparam int QUIET_TO   = 1000;

  typedef struct {
    logic hold;
    req_t req;
  } pend_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  req_t req_i  = '0;
  logic busy;
  logic done_o;
  res_t res_o;

  markov_chain_sampler_scorer_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Chain state mirrored from the accepted requests.
  logic [15:0] trans_p [NSTATES][NSTATES] = '{default: '{default: '0}};
  logic [15:0] init_p [NSTATES] = '{default: '0};
  logic [3:0]  cur_state = '0;
  logic [3:0]  last_sym  = '0;
  logic [15:0] seq_prob  = '0;

  pend_t pending_reqs[$];
  res_t  expected_res[$];

  int mismatches  = 0;
  int idle_cycles = 0;
  int n_queued    = 0;
  int sent        = 0;
  int n_writes    = 0;
  int n_samples   = 0;
  int n_saturated = 0;
  int n_scores    = 0;
  int hold_cnt    = 0;
  logic holding   = 1'b0;
  logic req_taken = 1'b0;

  task automatic put_req(input func_e f, input logic [3:0] rw, input logic [3:0] cl,
                         input logic [15:0] pv, input logic [15:0] un,
                         input logic [3:0] sym, input logic fst);
    pend_t p;
    p.hold           = 1'b0;
    p.req.func       = f;
    p.req.row        = rw;
    p.req.col        = cl;
    p.req.prob_value = pv;
    p.req.uniform    = un;
    p.req.symbol     = sym;
    p.req.first      = fst;
    pending_reqs.push_back(p);
    n_queued++;
  endtask

  task automatic put_hold();
    pend_t p;
    p.hold = 1'b1;
    p.req  = '0;
    pending_reqs.push_back(p);
  endtask

  // Load a whole probability row: normalized, sparse, full range or empty.
  task automatic fill_row(input logic is_init, input logic [3:0] r);
    int unsigned w [NSTATES];
    int unsigned total;
    int unsigned mode;
    int unsigned scaled;
    logic [15:0] v;
    mode  = $urandom_range(9);
    total = 0;
    for (int c = 0; c < NSTATES; c++) begin
      if (mode < 5) begin
        w[c] = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 255);
      end else if (mode < 7) begin
        w[c] = ($urandom_range(5) == 0) ? $urandom_range(1, 255) : 0;
      end else begin
        w[c] = 0;
      end
      total += w[c];
    end
    for (int c = 0; c < NSTATES; c++) begin
      if (mode == 7 || mode == 8) begin
        v = 16'($urandom);
      end else if (mode == 9 || total == 0) begin
        v = '0;
      end else begin
        scaled = w[c] * 65536 / total;
        v = (scaled > 65535) ? 16'hFFFF : scaled[15:0];
      end
      put_req(is_init ? FUNC_WR_INIT : FUNC_WR_TRANS, r, c[3:0], v, 16'($urandom),
              4'($urandom), 1'($urandom));
    end
  endtask

  // Update the mirrored chain and queue the result the request must produce.
  task automatic apply_request(input req_t r);
    res_t        want;
    logic [20:0] cum;
    logic [3:0]  pick;
    logic [31:0] prod;
    want = '0;
    case (r.func)
      FUNC_WR_TRANS: begin
        trans_p[r.row][r.col] = r.prob_value;
        n_writes++;
      end
      FUNC_WR_INIT: begin
        init_p[r.col] = r.prob_value;
        n_writes++;
      end
      FUNC_SAMPLE: begin
        pick = '0;
        cum  = 21'(r.first ? init_p[0] : trans_p[cur_state][0]);
        while (21'(r.uniform) >= cum && pick != 4'(NSTATES - 1)) begin
          pick++;
          cum += 21'(r.first ? init_p[pick] : trans_p[cur_state][pick]);
        end
        if (21'(r.uniform) >= cum) n_saturated++;
        cur_state          = pick;
        want.kind          = KIND_SAMPLE;
        want.sampled_state = pick;
        expected_res.push_back(want);
        n_samples++;
      end
      FUNC_SCORE: begin
        if (r.first) begin
          seq_prob = init_p[r.symbol];
        end else begin
          prod     = 32'(seq_prob) * 32'(trans_p[last_sym][r.symbol]);
          seq_prob = prod[31:16];
        end
        last_sym         = r.symbol;
        want.kind        = KIND_SCORE;
        want.probability = seq_prob;
        expected_res.push_back(want);
        n_scores++;
      end
      default: begin
      end
    endcase
  endtask

  // Driver: present requests at the falling edge.
  always @(negedge clk_i) begin
    logic  nxt_start;
    req_t  nxt_req;
    pend_t p;
    logic  quiet;
    nxt_start = start;
    nxt_req   = req_i;
    if (!rst_ni) begin
      nxt_start = 1'b0;
    end else if (!start || req_taken) begin
      nxt_start = 1'b0;
      if (holding) begin
        if (expected_res.size() == 0 && !busy) hold_cnt++;
        if (hold_cnt >= 4) holding = 1'b0;
      end else if (pending_reqs.size() != 0) begin
        quiet = (sent >= QUIET_FROM && sent < QUIET_TO);
        if (quiet || $urandom_range(99) >= 33) begin
          p = pending_reqs.pop_front();
          if (p.hold) begin
            holding  = 1'b1;
            hold_cnt = 0;
          end else begin
            nxt_start = 1'b1;
            nxt_req   = p.req;
            sent++;
          end
        end
      end
    end
    start <= nxt_start;
    req_i <= nxt_req;
  end

  // Monitor: check results and accept requests at the rising edge.
  always @(posedge clk_i) begin
    logic moved;
    res_t want;
    if (!rst_ni) begin
      req_taken   <= 1'b0;
      idle_cycles <= 0;
    end else begin
      moved = 1'b0;
      if (done_o) begin
        moved = 1'b1;
        if (expected_res.size() == 0) begin
          $error("result with nothing outstanding: kind %0d state %0d prob %0h",
                 res_o.kind, res_o.sampled_state, res_o.probability);
          mismatches++;
        end else begin
          want = expected_res.pop_front();
          if (res_o.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, res_o.kind);
            mismatches++;
          end
          if (res_o.sampled_state !== want.sampled_state) begin
            $error("sampled_state: expected %0d, got %0d", want.sampled_state,
                   res_o.sampled_state);
            mismatches++;
          end
          if (res_o.probability !== want.probability) begin
            $error("probability: expected %0h, got %0h", want.probability,
                   res_o.probability);
            mismatches++;
          end
        end
      end
      req_taken <= start && !busy;
      if (start && !busy) begin
        moved = 1'b1;
        apply_request(req_i);
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG) @(posedge clk_i);
    $error("no request or result for %0d cycles", WATCHDOG);
    $display("FAIL");
    $finish;
  end

  initial begin
    int   r;
    int   len;
    logic mid_hold;
    mid_hold = 1'b0;

    // Empty tables: every pick saturates, every product is zero.
    put_req(FUNC_SAMPLE, 4'd0, 4'd0, 16'h0000, 16'h0000, 4'd0, 1'b1);
    put_req(FUNC_SAMPLE, 4'd15, 4'd15, 16'hFFFF, 16'hFFFF, 4'd15, 1'b0);
    put_req(FUNC_SCORE, 4'd0, 4'd0, 16'h0000, 16'h0000, 4'd15, 1'b1);
    put_req(FUNC_SCORE, 4'd0, 4'd0, 16'h0000, 16'h0000, 4'd0, 1'b0);
    // Zero-probability first state is skipped; draws past the earlier mass pick the last state.
    put_req(FUNC_WR_INIT, 4'd0, 4'd0, 16'h0000, 16'h0000, 4'd0, 1'b0);
    put_req(FUNC_WR_INIT, 4'd0, 4'd1, 16'h4000, 16'h0000, 4'd0, 1'b0);
    put_req(FUNC_WR_INIT, 4'd15, 4'd15, 16'hFFFF, 16'hFFFF, 4'd15, 1'b1);
    put_req(FUNC_SAMPLE, 4'd0, 4'd0, 16'h0000, 16'h0000, 4'd0, 1'b1);
    put_req(FUNC_SAMPLE, 4'd0, 4'd0, 16'h0000, 16'h3FFF, 4'd0, 1'b1);
    put_req(FUNC_SAMPLE, 4'd0, 4'd0, 16'h0000, 16'h4000, 4'd0, 1'b1);
    put_req(FUNC_SAMPLE, 4'd0, 4'd0, 16'h0000, 16'hFFFF, 4'd0, 1'b1);
    // Walk from the current row rather than row zero.
    put_req(FUNC_WR_TRANS, 4'd15, 4'd0, 16'hFFFF, 16'h0000, 4'd0, 1'b0);
    put_req(FUNC_WR_TRANS, 4'd15, 4'd15, 16'hFFFF, 16'h0000, 4'd0, 1'b0);
    put_req(FUNC_WR_TRANS, 4'd0, 4'd15, 16'h0001, 16'h0000, 4'd0, 1'b0);
    put_req(FUNC_SAMPLE, 4'd0, 4'd0, 16'h0000, 16'hFFFE, 4'd0, 1'b0);
    put_req(FUNC_SAMPLE, 4'd0, 4'd0, 16'h0000, 16'h0000, 4'd0, 1'b0);
    // Score start, full-scale truncation, and a product that falls to zero.
    put_req(FUNC_SCORE, 4'd0, 4'd0, 16'h0000, 16'h0000, 4'd15, 1'b1);
    put_req(FUNC_SCORE, 4'd0, 4'd0, 16'h0000, 16'h0000, 4'd15, 1'b0);
    put_req(FUNC_SCORE, 4'd0, 4'd0, 16'h0000, 16'h0000, 4'd0, 1'b0);
    put_req(FUNC_SCORE, 4'd0, 4'd0, 16'h0000, 16'h0000, 4'd15, 1'b0);
    put_req(FUNC_SCORE, 4'd0, 4'd0, 16'h0000, 16'h0000, 4'd0, 1'b1);
    put_hold();

    // Load the whole chain, then run sequences against it with edits between.
    fill_row(1'b1, 4'd0);
    for (int i = 0; i < NSTATES; i++) fill_row(1'b0, i[3:0]);
    while (n_queued < RAND_ITEMS + 21) begin
      if (!mid_hold && n_queued >= 1100) begin
        put_hold();
        mid_hold = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 8) begin
        fill_row($urandom_range(4) == 0, 4'($urandom));
      end else if (r < 20) begin
        len = $urandom_range(1, 3);
        for (int k = 0; k < len; k++) begin
          put_req(func_e'($urandom_range(1)), 4'($urandom), 4'($urandom),
                  16'($urandom), 16'($urandom), 4'($urandom), 1'($urandom));
        end
      end else if (r < 55) begin
        len = $urandom_range(2, 16);
        for (int k = 0; k < len; k++) begin
          put_req(FUNC_SAMPLE, 4'($urandom), 4'($urandom), 16'($urandom),
                  16'($urandom), 4'($urandom),
                  (k == 0) || ($urandom_range(19) == 0));
        end
      end else if (r < 90) begin
        len = $urandom_range(2, 16);
        for (int k = 0; k < len; k++) begin
          put_req(FUNC_SCORE, 4'($urandom), 4'($urandom), 16'($urandom),
                  16'($urandom), 4'($urandom),
                  (k == 0) || ($urandom_range(19) == 0));
        end
      end else begin
        put_req(func_e'($urandom_range(3)), 4'($urandom), 4'($urandom),
                16'($urandom), 16'($urandom), 4'($urandom), 1'($urandom));
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || holding || start) @(posedge clk_i);
    while (expected_res.size() != 0) @(posedge clk_i);
    repeat (NSTATES + 4) @(posedge clk_i);

    $display("Requests sent: %0d; table writes %0d, score steps %0d", sent, n_writes,
             n_scores);
    $display("Sample steps %0d, of which %0d ran past the row mass to the last state",
             n_samples, n_saturated);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/mcss_pkg.sv
rtl/mcss_ctrl.sv
rtl/mcss_dp.sv
rtl/markov_chain_sampler_scorer_top.sv
dv/markov_chain_sampler_scorer_top_tb.sv
